// File: design/ckhm_pkg.sv
// ----------------------------------------------------------------------------
// ckhm_pkg
// Shared widths, register indexes and reset values for the hue chroma key.
// ----------------------------------------------------------------------------
`default_nettype none

package ckhm_pkg;

    localparam int unsigned HUE_FRAC_BITS_DEF = 6;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned HUE_W      = 15;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 48;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [PIX_W-1:0]     t_pix;

    localparam t_cfg_idx CFG_KEY_HUE     = 2'd0;
    localparam t_cfg_idx CFG_HUE_THRESH  = 2'd1;
    localparam t_cfg_idx CFG_PREMULTIPLY = 2'd2;

    localparam logic [HUE_W-1:0] KEY_HUE_RST    = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_THRESH_RST = 15'd1280;

    localparam t_pix ALPHA_KEYED  = 8'h00;
    localparam t_pix ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

// File: design/chroma_key_hue_mask.sv
// ----------------------------------------------------------------------------
// chroma_key_hue_mask
// Per-pixel HSV hue and hue-distance key with optional premultiplied color.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel (red, green, blue) and leave on the
// m_axis channel with the color, alpha and the computed hue. One transfer
// in gives one transfer out, in order.
// Registers key_hue, hue_threshold and premultiply are written over the cfg
// channel (always ready); write them only while no pixel is in flight.
// Throughput: one pixel per clock unless a stalled receiver fills the skid.
// The hue quotient is QW = HUE_FRAC_BITS + 9 bits wide, produced by the
// restoring divider that retires one quotient bit per stage.
// The datapath advances as one pipeline; an output register plus a skid
// register absorb a stalled receiver, so input stays ready until the skid
// fills, then the whole pipeline holds with nothing lost.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_key_hue_mask #(
    parameter int unsigned HUE_FRAC_BITS = ckhm_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    input  wire  [ckhm_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], alpha[31:24],
    // hue[46:32], zero[47]
    output logic [ckhm_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ckhm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [ckhm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ckhm_pkg::*;

    localparam int unsigned SCALE = 60 * (2 ** HUE_FRAC_BITS);
    localparam int unsigned H360  = 360 * (2 ** HUE_FRAC_BITS);
    localparam int unsigned QW    = $clog2(5 * SCALE + 1);
    localparam int unsigned NW    = QW + PIX_W;
    localparam int unsigned NUM_W = PIX_W + 3;
    localparam int unsigned HW    = $clog2(H360);
    localparam int unsigned DW    = ((HW > HUE_W) ? HW : HUE_W) + 1;

    logic [HUE_W-1:0] r_key_hue;
    logic [HUE_W-1:0] r_hue_thr;
    logic             r_premul;

    logic en;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hue <= KEY_HUE_RST;
            r_hue_thr <= HUE_THRESH_RST;
            r_premul  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_HUE:     r_key_hue <= i_cfg_data;
                CFG_HUE_THRESH:  r_hue_thr <= i_cfg_data;
                CFG_PREMULTIPLY: r_premul  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: max/min, delta, sector numerator
    t_pix             in_r, in_g, in_b;
    t_pix             n_mx, n_mn, n_d;
    logic             n_red_max, n_grn_max, n_neg;
    logic [NUM_W-1:0] n_num;

    assign in_r = i_s_axis_tdata[7:0];
    assign in_g = i_s_axis_tdata[15:8];
    assign in_b = i_s_axis_tdata[23:16];

    always_comb begin
        n_red_max = (in_r >= in_g) && (in_r >= in_b);
        n_grn_max = !n_red_max && (in_g >= in_b);
        n_mx = n_red_max ? in_r : (n_grn_max ? in_g : in_b);
        if (in_g <= in_r && in_g <= in_b) begin
            n_mn = in_g;
        end else if (in_b <= in_r) begin
            n_mn = in_b;
        end else begin
            n_mn = in_r;
        end
        n_d   = n_mx - n_mn;
        n_neg = n_red_max && (in_g < in_b);
        if (n_red_max) begin
            n_num = n_neg ? NUM_W'(in_b - in_g) : NUM_W'(in_g - in_b);
        end else if (n_grn_max) begin
            n_num = {2'b00, n_d, 1'b0} + NUM_W'(in_b) - NUM_W'(in_r);
        end else begin
            n_num = {1'b0, n_d, 2'b00} + NUM_W'(in_r) - NUM_W'(in_g);
        end
    end

    logic             r_p1_vld;
    logic [S_TDATA_W-1:0] r_p1_rgb;
    t_pix             r_p1_d;
    logic [NUM_W-1:0] r_p1_num;
    logic             r_p1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_rgb <= i_s_axis_tdata;
            r_p1_d   <= n_d;
            r_p1_num <= n_num;
            r_p1_neg <= n_neg;
        end
    end

    // stage 2: scale numerator, seed divider
    logic [NW-1:0] n_prod;
    assign n_prod = NW'(r_p1_num) * NW'(SCALE);

    logic                 r_dv_vld  [0:QW];
    logic [S_TDATA_W-1:0] r_dv_rgb  [0:QW];
    t_pix                 r_dv_d    [0:QW];
    logic                 r_dv_neg  [0:QW];
    logic                 r_dv_zero [0:QW];
    t_pix                 r_dv_rem  [0:QW];
    logic [QW-1:0]        r_dv_w    [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rgb[0]  <= r_p1_rgb;
            r_dv_d[0]    <= r_p1_d;
            r_dv_neg[0]  <= r_p1_neg;
            r_dv_zero[0] <= (r_p1_d == '0);
            r_dv_rem[0]  <= n_prod[NW-1:QW];
            r_dv_w[0]    <= n_prod[QW-1:0];
        end
    end

    // restoring divider, one quotient bit per stage; quotient shifts into w
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [PIX_W:0] n_trial;
        logic           n_ge;

        always_comb begin
            n_trial = {r_dv_rem[j], r_dv_w[j][QW-1]};
            n_ge    = n_trial >= {1'b0, r_dv_d[j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rgb[j+1]  <= r_dv_rgb[j];
                r_dv_d[j+1]    <= r_dv_d[j];
                r_dv_neg[j+1]  <= r_dv_neg[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                r_dv_rem[j+1]  <= n_ge ? PIX_W'(n_trial - {1'b0, r_dv_d[j]})
                                       : n_trial[PIX_W-1:0];
                r_dv_w[j+1]    <= {r_dv_w[j][QW-2:0], n_ge};
            end
        end
    end

    // stage A: zero hue for zero delta, sign fix-up, wrap negative hue
    logic [HW-1:0] n_a_hue;
    always_comb begin
        if (r_dv_zero[QW]) begin
            n_a_hue = '0;
        end else if (r_dv_neg[QW] && (r_dv_w[QW] != '0)) begin
            n_a_hue = HW'(H360) - HW'(r_dv_w[QW]);
        end else begin
            n_a_hue = HW'(r_dv_w[QW]);
        end
    end

    logic                 r_a_vld;
    logic [S_TDATA_W-1:0] r_a_rgb;
    logic [HW-1:0]        r_a_hue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rgb <= r_dv_rgb[QW];
            r_a_hue <= n_a_hue;
        end
    end

    // stage B: absolute hue distance
    logic [DW-1:0] n_b_d1, n_b_d2;
    assign n_b_d1 = DW'(r_a_hue) - DW'(r_key_hue);
    assign n_b_d2 = DW'(r_key_hue) - DW'(r_a_hue);

    logic                 r_b_vld;
    logic [S_TDATA_W-1:0] r_b_rgb;
    logic [HW-1:0]        r_b_hue;
    logic [DW-1:0]        r_b_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rgb  <= r_a_rgb;
            r_b_hue  <= r_a_hue;
            r_b_dist <= n_b_d1[DW-1] ? n_b_d2 : n_b_d1;
        end
    end

    // stage C: key decision, premultiply
    logic n_c_keyed;
    assign n_c_keyed = r_b_dist <= DW'(r_hue_thr);

    logic                 r_c_vld;
    logic [M_TDATA_W-1:0] r_c_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_data[23:0]  <= (n_c_keyed && r_premul) ? '0 : r_b_rgb;
            r_c_data[31:24] <= n_c_keyed ? ALPHA_KEYED : ALPHA_OPAQUE;
            r_c_data[46:32] <= HUE_W'(r_b_hue);
            r_c_data[47]    <= 1'b0;
        end
    end

    // output register and skid
    logic                 r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_skd_vld;
    logic [M_TDATA_W-1:0] r_skd_data;
    logic                 take;

    assign en              = !r_skd_vld;
    assign o_s_axis_tready = en;
    assign take            = r_out_vld && i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (take) begin
                r_skd_vld <= 1'b0;
            end
        end else if (r_c_vld) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skd_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (take) begin
                r_out_data <= r_skd_data;
            end
        end else if (r_c_vld) begin
            if (!r_out_vld || take) begin
                r_out_data <= r_c_data;
            end else begin
                r_skd_data <= r_c_data;
            end
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid holds a transfer while output register is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_vld && !i_m_axis_tready) |=> (r_skd_vld && !o_s_axis_tready))
        else $error("skid dropped while receiver stalled");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_a_hue < HW'(H360)))
        else $error("hue out of range");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c_data[31:24] == ALPHA_KEYED || r_c_data[31:24] == ALPHA_OPAQUE))
        else $error("alpha is neither keyed nor opaque");

endmodule

`default_nettype wire

// File: test/chroma_key_hue_mask_tb.sv
// ----------------------------------------------------------------------------
// chroma_key_hue_mask_tb
// Self-checking bench for the hue chroma key: a directed table of pixels and
// register writes, then random pixel phases under changing key settings, with
// random stalls on both streams. Every output transfer is checked field by
// field against table values where a row gives them, else an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chroma_key_hue_mask_tb;

    import ckhm_pkg::*;

    localparam int HUE_F         = HUE_FRAC_BITS_DEF;
    localparam int HUE_SCALE     = 60 << HUE_F;
    localparam int HUE_CIRCLE    = 360 << HUE_F;
    localparam int LATENCY       = HUE_F + 14;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASES        = 6;
    localparam int PHASE_PIXELS  = 200;
    localparam int N_ROWS        = 36;

    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef logic [HUE_W-1:0] t_hue;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        t_pix alpha;
        t_hue hue;
    } t_keyed_px;

    typedef enum logic {ROW_PIXEL, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_cfg_idx               idx;
        logic [CFG_DATA_W-1:0]  value;
        t_pix                   red;
        t_pix                   green;
        t_pix                   blue;
        logic                   typed;
        t_hue                   t_hue_v;
        t_pix                   t_alpha;
    } t_stim_row;

    // kind, index, value, r, g, b, typed, hue, alpha
    localparam t_stim_row DIR_ROWS [0:N_ROWS-1] = '{
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd1,   1'b1, 15'd23025, ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, ALPHA_OPAQUE},
        // both edges of the default key window
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd1,   8'd3,   8'd0,   1'b1, 15'd6400,  ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd3,   8'd1,   1'b1, 15'd8960,  ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd128, 8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd37,  8'd200, 8'd90,  1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_CFG,   CFG_PREMULTIPLY, 15'd1, 8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, ALPHA_OPAQUE},
        '{ROW_CFG,   CFG_KEY_HUE, 15'd0,     8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_CFG,   CFG_HUE_THRESH, 15'd0,  8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd10,  8'd250, 8'd20,  1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd1,   1'b1, 15'd23025, ALPHA_OPAQUE},
        // threshold past the hue range keys everything
        '{ROW_CFG,   CFG_HUE_THRESH, 15'h7FFF, 8'd0, 8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd1,   1'b1, 15'd23025, ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     ALPHA_KEYED},
        '{ROW_CFG,   CFG_KEY_HUE, 15'h7FFF,  8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_CFG,   CFG_HUE_THRESH, 15'd0,  8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        // only bit 0 of premultiply counts
        '{ROW_CFG,   CFG_PREMULTIPLY, 15'h7FFE, 8'd0, 8'd0,  8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd255, 8'd0,   8'd1,   1'b1, 15'd23025, ALPHA_OPAQUE},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  ALPHA_OPAQUE},
        '{ROW_CFG,   CFG_KEY_HUE, 15'd23039, 8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_CFG,   CFG_HUE_THRESH, 15'd23040, 8'd0, 8'd0,  8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     ALPHA_KEYED},
        // write to the unused index must not touch the threshold
        '{ROW_CFG,   CFG_SPARE, 15'd0,       8'd0,   8'd0,   8'd0,   1'b0, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     ALPHA_KEYED},
        '{ROW_PIXEL, CFG_KEY_HUE, 15'd0,     8'd90,  8'd12,  8'd200, 1'b0, 15'd0,     ALPHA_KEYED}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_hue       key_hue_cfg = KEY_HUE_RST;
    t_hue       thresh_cfg  = HUE_THRESH_RST;
    logic       premult_cfg = 1'b0;

    t_keyed_px  keyed_px_q[$];
    t_keyed_px  head_px;
    int         mismatches = 0;
    int         idle_pct = 20;
    int         hold_cnt = 0;
    int         quiet_cycles = 0;

    chroma_key_hue_mask DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_keyed_px key_pixel(input t_pix r, input t_pix g, input t_pix b);
        int        rv, gv, bv, mx, mn, d, num, h, hue_gap;
        t_keyed_px res;
        rv = r;
        gv = g;
        bv = b;
        mx = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        mn = rv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        d = mx - mn;
        if (mx == 0 || d == 0) begin
            h = 0;
        end else begin
            if (rv == mx) begin
                num = gv - bv;
            end else if (gv == mx) begin
                num = 2 * d + bv - rv;
            end else begin
                num = 4 * d + rv - gv;
            end
            h = (num * HUE_SCALE) / d;
            if (h < 0) h = h + HUE_CIRCLE;
        end
        hue_gap = h - int'(key_hue_cfg);
        if (hue_gap < 0) hue_gap = -hue_gap;
        res.alpha = (hue_gap <= int'(thresh_cfg)) ? ALPHA_KEYED : ALPHA_OPAQUE;
        if (res.alpha == ALPHA_KEYED && premult_cfg) begin
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
        end else begin
            res.red   = r;
            res.green = g;
            res.blue  = b;
        end
        res.hue = h[HUE_W-1:0];
        return res;
    endfunction

    function automatic t_pix rail_value();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return t_pix'($urandom);
        endcase
    endfunction

    // packed as {blue, green, red}
    function automatic logic [23:0] rand_pixel();
        t_pix a, c;
        a = t_pix'($urandom);
        c = t_pix'($urandom);
        case ($urandom_range(0, 9))
            0: return {a, a, a};
            1, 2: begin
                case ($urandom_range(0, 2))
                    0: return {c, a, a};
                    1: return {a, c, a};
                    default: return {a, a, c};
                endcase
            end
            3: return {t_pix'($urandom_range(0, 3)), t_pix'($urandom_range(0, 3)),
                       t_pix'($urandom_range(0, 3))};
            4: return {rail_value(), rail_value(), rail_value()};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_KEY_HUE:     key_hue_cfg = value;
            CFG_HUE_THRESH:  thresh_cfg  = value;
            CFG_PREMULTIPLY: premult_cfg = value[0];
            default: ;
        endcase
    endtask

    task automatic drain_pixels();
        i_s_axis_tvalid <= 1'b0;
        while (keyed_px_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pix r, input t_pix g, input t_pix b,
                              input logic typed, input t_hue t_hue_v, input t_pix t_alpha);
        t_keyed_px want;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, g, r};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        want = key_pixel(r, g, b);
        if (typed) begin
            want.hue   = t_hue_v;
            want.alpha = t_alpha;
            if (t_alpha == ALPHA_KEYED && premult_cfg) begin
                want.red   = '0;
                want.green = '0;
                want.blue  = '0;
            end else begin
                want.red   = r;
                want.green = g;
                want.blue  = b;
            end
        end
        keyed_px_q = {keyed_px_q, want};
    endtask

    // output side: check, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (keyed_px_q.size() == 0) begin
                $display("%0t: output transfer, expected none, got %h", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                head_px = keyed_px_q.pop_front();
                check_field("out_red",   head_px.red,   o_m_axis_tdata[7:0]);
                check_field("out_green", head_px.green, o_m_axis_tdata[15:8]);
                check_field("out_blue",  head_px.blue,  o_m_axis_tdata[23:16]);
                check_field("alpha",     head_px.alpha, o_m_axis_tdata[31:24]);
                check_field("hue",       head_px.hue,   o_m_axis_tdata[46:32]);
                check_field("pad",       0,             o_m_axis_tdata[47]);
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            hold_cnt = $urandom_range(0, 17);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [23:0]            px;
        logic [CFG_DATA_W-1:0]  key_v, thr_v, prem_v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            if (DIR_ROWS[k].kind == ROW_CFG) begin
                drain_pixels();
                cfg_write(DIR_ROWS[k].idx, DIR_ROWS[k].value);
            end else begin
                i_cfg_valid <= 1'b0;
                send_pixel(DIR_ROWS[k].red, DIR_ROWS[k].green, DIR_ROWS[k].blue,
                           DIR_ROWS[k].typed, DIR_ROWS[k].t_hue_v, DIR_ROWS[k].t_alpha);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pixels();
            idle_pct = (ph == PHASES - 1) ? 0 : $urandom_range(0, 3) * 15;
            case (ph)
                0: begin
                    key_v = '0;
                    thr_v = '0;
                end
                1: begin
                    key_v = 15'd23039;
                    thr_v = 15'd23040;
                end
                2: begin
                    key_v = CFG_DATA_W'($urandom);
                    thr_v = CFG_DATA_W'($urandom);
                end
                default: begin
                    key_v = CFG_DATA_W'($urandom_range(0, 23039));
                    thr_v = CFG_DATA_W'($urandom_range(0, 2560));
                end
            endcase
            prem_v    = CFG_DATA_W'($urandom);
            prem_v[0] = ph[0];
            cfg_write(CFG_KEY_HUE, key_v);
            cfg_write(CFG_HUE_THRESH, thr_v);
            cfg_write(CFG_PREMULTIPLY, prem_v);
            if ($urandom_range(0, 1)) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;
            repeat (PHASE_PIXELS) begin
                px = rand_pixel();
                send_pixel(px[7:0], px[15:8], px[23:16], 1'b0, '0, ALPHA_OPAQUE);
            end
        end

        drain_pixels();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
